### sv/insertable_byte_list_core_macros.svh
// Assertion macros for the insertable byte list.
// Both expect clk and rst_n in the scope where they are used.
`ifndef INSERTABLE_BYTE_LIST_CORE_MACROS_SVH
`define INSERTABLE_BYTE_LIST_CORE_MACROS_SVH

// Same-cycle implication.
`define IBL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define IBL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/ibl_pkg.sv
// ----------------------------------------------------------------------------
// ibl_pkg
// Types and constants shared by the insertable byte list and its cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ibl_pkg;

  localparam int CAPACITY = 64;

  localparam int POS_W   = 6;
  localparam int BYTE_W  = 8;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 7;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_SET    = 2'd2;
  localparam logic [OP_W-1:0] OP_GET    = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  position;
    logic [BYTE_W-1:0] write_value;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  read_value;
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] count_after;
  } out_t;

  // Broadcast to every cell for one transaction.
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic              wr;
    logic [POS_W-1:0]  pos;
    logic [BYTE_W-1:0] wv;
  } ctl_t;

endpackage

### sv/ibl_cell.sv
// ----------------------------------------------------------------------------
// ibl_cell
// One list entry: holds a byte, takes a neighbour's byte on a shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ibl_cell (
  input  logic                      clk,
  input  ibl_pkg::ctl_t             ctl,
  input  logic [ibl_pkg::IDX_W-1:0] idx,
  input  logic [ibl_pkg::BYTE_W-1:0] lo_data,
  input  logic [ibl_pkg::BYTE_W-1:0] hi_data,
  output logic [ibl_pkg::BYTE_W-1:0] data,
  output logic [ibl_pkg::BYTE_W-1:0] pick
);

  logic [ibl_pkg::BYTE_W-1:0] data_r;
  logic [ibl_pkg::BYTE_W-1:0] data_nxt;
  logic [ibl_pkg::CMP_W-1:0]  idx_c;
  logic [ibl_pkg::CMP_W-1:0]  pos_c;
  logic                       at_pos;

  assign idx_c  = ibl_pkg::CMP_W'(idx);
  assign pos_c  = ibl_pkg::CMP_W'(ctl.pos);
  assign at_pos = (idx_c == pos_c);

  always_comb begin
    data_nxt = data_r;
    if (ctl.ins) begin
      // open a gap: everything above the position moves up
      if (idx_c > pos_c) begin
        data_nxt = lo_data;
      end else if (at_pos) begin
        data_nxt = ctl.wv;
      end
    end else if (ctl.rem) begin
      if (idx_c >= pos_c) begin
        data_nxt = hi_data;
      end
    end else if (ctl.wr && at_pos) begin
      data_nxt = ctl.wv;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;
  assign pick = at_pos ? data_r : '0;

endmodule

### sv/insertable_byte_list_core.sv
// Insertable byte list: a row of byte cells that shift together.
// Result: out_valid strobes in the cycle after start is taken.
// Throughput: one request per cycle; every cell shifts in the same edge, so busy stays low.
// Reset: synchronous, active low; empties the list and drops any pending result.
// Cell contents are not cleared; entries at or above the count are never read.
// ----------------------------------------------------------------------------
// insertable_byte_list_core
// Ordered byte list with insert, remove, set and get at a position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module insertable_byte_list_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  ibl_pkg::in_t  in_data,
  output logic          out_valid,
  output ibl_pkg::out_t out_data
);

  logic [ibl_pkg::CNT_W-1:0]  count_r;
  logic [ibl_pkg::CNT_W-1:0]  count_nxt;
  logic                       out_valid_r;
  ibl_pkg::out_t              out_r;
  ibl_pkg::out_t              out_nxt;
  ibl_pkg::ctl_t              ctl;
  logic                       accept;
  logic [ibl_pkg::CMP_W-1:0]  pos_c;
  logic [ibl_pkg::CMP_W-1:0]  cnt_c;
  logic [ibl_pkg::STAT_W-1:0] status;
  logic [ibl_pkg::BYTE_W-1:0] rd_sel;
  logic [ibl_pkg::BYTE_W-1:0] data_w [ibl_pkg::CAPACITY];
  logic [ibl_pkg::BYTE_W-1:0] pick_w [ibl_pkg::CAPACITY];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign pos_c  = ibl_pkg::CMP_W'(in_data.position);
  assign cnt_c  = ibl_pkg::CMP_W'(count_r);

  always_comb begin
    status = ibl_pkg::ST_OK;
    if (in_data.op == ibl_pkg::OP_INSERT) begin
      // range test takes priority over full
      if (pos_c > cnt_c) begin
        status = ibl_pkg::ST_RANGE;
      end else if (count_r == ibl_pkg::CNT_W'(ibl_pkg::CAPACITY)) begin
        status = ibl_pkg::ST_FULL;
      end
    end else if (pos_c >= cnt_c) begin
      status = ibl_pkg::ST_RANGE;
    end
  end

  always_comb begin
    ctl     = '0;
    ctl.pos = in_data.position;
    ctl.wv  = in_data.write_value;
    if (accept && status == ibl_pkg::ST_OK) begin
      case (in_data.op)
        ibl_pkg::OP_INSERT: ctl.ins = 1'b1;
        ibl_pkg::OP_REMOVE: ctl.rem = 1'b1;
        ibl_pkg::OP_SET:    ctl.wr  = 1'b1;
        default:            ctl     = ctl;
      endcase
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.ins) begin
      count_nxt = count_r + ibl_pkg::CNT_W'(1);
    end else if (ctl.rem) begin
      count_nxt = count_r - ibl_pkg::CNT_W'(1);
    end
  end

  // only the cell at the position drives a non-zero pick
  always_comb begin
    rd_sel = '0;
    for (int k = 0; k < ibl_pkg::CAPACITY; k++) begin
      rd_sel = rd_sel | pick_w[k];
    end
  end

  always_comb begin
    out_nxt             = '0;
    out_nxt.status      = status;
    out_nxt.count_after = ibl_pkg::COUNT_W'(count_nxt);
    if (status == ibl_pkg::ST_OK &&
        (in_data.op == ibl_pkg::OP_REMOVE || in_data.op == ibl_pkg::OP_GET)) begin
      out_nxt.read_value = rd_sel;
    end
  end

  for (genvar k = 0; k < ibl_pkg::CAPACITY; k++) begin : g_cell
    logic [ibl_pkg::BYTE_W-1:0] lo_d;
    logic [ibl_pkg::BYTE_W-1:0] hi_d;

    if (k == 0) begin : g_first
      assign lo_d = '0;
    end else begin : g_lo
      assign lo_d = data_w[k-1];
    end

    if (k == ibl_pkg::CAPACITY - 1) begin : g_last
      assign hi_d = '0;
    end else begin : g_hi
      assign hi_d = data_w[k+1];
    end

    ibl_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .idx     (ibl_pkg::IDX_W'(k)),
      .lo_data (lo_d),
      .hi_data (hi_d),
      .data    (data_w[k]),
      .pick    (pick_w[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### sv/ibl_checker.sv
// ----------------------------------------------------------------------------
// ibl_checker
// Port-level checks on the insertable byte list, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "insertable_byte_list_core_macros.svh"

module ibl_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_valid,
  input ibl_pkg::out_t out_data
);

  logic [ibl_pkg::COUNT_W-1:0] cnt_prev_r;
  logic                        taken;
  logic                        res_err;
  logic                        res_full;
  logic                        at_cap;
  logic                        cnt_step_ok;

  // hold the count of the previous cycle's result
  always_ff @(posedge clk) begin
    cnt_prev_r <= out_data.count_after;
  end

  assign taken       = start && !busy;
  assign res_err     = out_valid && (out_data.status != ibl_pkg::ST_OK);
  assign res_full    = out_valid && (out_data.status == ibl_pkg::ST_FULL);
  assign at_cap      = (out_data.count_after == ibl_pkg::COUNT_W'(ibl_pkg::CAPACITY));
  assign cnt_step_ok = (out_data.count_after == cnt_prev_r) ||
                       (out_data.count_after == cnt_prev_r + ibl_pkg::COUNT_W'(1)) ||
                       (out_data.count_after == cnt_prev_r - ibl_pkg::COUNT_W'(1));

  `IBL_ASSERT_NXT(a_result_follows, taken, out_valid, "transaction gave no result")
  `IBL_ASSERT_NXT(a_no_spurious, !taken, !out_valid, "result without a transaction")
  `IBL_ASSERT_IMP(a_err_zero, res_err, out_data.read_value == '0, "failed transaction returned data")
  `IBL_ASSERT_IMP(a_full_count, res_full, at_cap, "full status below capacity")
  `IBL_ASSERT_IMP(a_count_step, out_valid && $past(out_valid), cnt_step_ok, "count moved by more than one")

endmodule

bind insertable_byte_list_core ibl_checker u_ibl_checker (.*);

### sim/insertable_byte_list_core_tb.sv
// ----------------------------------------------------------------------------
// insertable_byte_list_core_tb
// Self-checking bench for the byte list: a directed pass over the edge cases,
// then phased random traffic that fills, drains and churns the list, checked
// transaction by transaction against a behavioural copy of the list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module insertable_byte_list_core_tb;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 10;
  localparam int RANDOM_ITEMS = 1200;
  localparam int MAX_GAP      = 11;
  localparam int QUIET_LIMIT  = 200;

  typedef enum int {PH_GROW, PH_MIXED, PH_SHRINK} phase_t;

  class byte_list_scoreboard;
    logic [ibl_pkg::BYTE_W-1:0] cells [ibl_pkg::CAPACITY];
    int unsigned                fill;
    ibl_pkg::out_t              awaited_replies [$];
    int                         errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    // Apply one request to the list copy and return the reply it gives.
    function ibl_pkg::out_t apply_request(ibl_pkg::in_t req);
      ibl_pkg::out_t reply;
      int unsigned   p;
      int unsigned   k;
      reply  = '0;
      reply.status = ibl_pkg::ST_OK;
      p = 32'(req.position);
      case (req.op)
        ibl_pkg::OP_INSERT: begin
          if (p > fill) begin
            reply.status = ibl_pkg::ST_RANGE;
          end else if (fill >= ibl_pkg::CAPACITY) begin
            reply.status = ibl_pkg::ST_FULL;
          end else begin
            for (k = fill; k > p; k--) cells[k] = cells[k - 1];
            cells[p] = req.write_value;
            fill++;
          end
        end
        ibl_pkg::OP_REMOVE: begin
          if (p >= fill) begin
            reply.status = ibl_pkg::ST_RANGE;
          end else begin
            reply.read_value = cells[p];
            for (k = p; k + 1 < fill; k++) cells[k] = cells[k + 1];
            fill--;
          end
        end
        ibl_pkg::OP_SET: begin
          if (p >= fill) reply.status = ibl_pkg::ST_RANGE;
          else cells[p] = req.write_value;
        end
        default: begin
          if (p >= fill) reply.status = ibl_pkg::ST_RANGE;
          else reply.read_value = cells[p];
        end
      endcase
      reply.count_after = ibl_pkg::COUNT_W'(fill);
      return reply;
    endfunction

    function void note_request(ibl_pkg::in_t req);
      awaited_replies.push_back(apply_request(req));
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(ibl_pkg::out_t got);
      ibl_pkg::out_t want;
      if (awaited_replies.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = awaited_replies.pop_front();
      compare_field("read_value", 32'(want.read_value), 32'(got.read_value));
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("count_after", 32'(want.count_after), 32'(got.count_after));
    endfunction

    function int outstanding();
      return awaited_replies.size();
    endfunction
  endclass

  logic          clk     = 1'b0;
  logic          rst_n   = 1'b0;
  logic          start   = 1'b0;
  ibl_pkg::in_t  in_data = '0;
  logic          busy;
  logic          out_valid;
  ibl_pkg::out_t out_data;

  byte_list_scoreboard sb = new();

  int unsigned gen_fill = 0;
  bit          gaps_on  = 1'b1;
  int          quiet_cycles = 0;

  insertable_byte_list_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    forever #HALF_PERIOD clk = ~clk;
  end

  // Check results first, then log the transaction taken at this edge.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_data);
    if (rst_n && start && !busy) sb.note_request(in_data);
    if (rst_n && (out_valid || (start && !busy))) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("insertable_byte_list_core_tb NOT OK");
      $finish;
    end
  end

  // Present one request and hold it until it is taken.
  task automatic send_request(logic [ibl_pkg::OP_W-1:0] op, int unsigned pos,
                              logic [ibl_pkg::BYTE_W-1:0] wv);
    ibl_pkg::in_t req;
    bit           stalled;
    int           gap;
    req.op          = op;
    req.position    = ibl_pkg::POS_W'(pos);
    req.write_value = wv;
    // Track the count alone, to aim positions at the live part of the list.
    if (op == ibl_pkg::OP_INSERT && 32'(req.position) <= gen_fill &&
        gen_fill < ibl_pkg::CAPACITY) gen_fill++;
    if (op == ibl_pkg::OP_REMOVE && 32'(req.position) < gen_fill) gen_fill--;
    gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= req;
    do begin
      @(negedge clk);
      stalled = busy;
      @(posedge clk);
    end while (stalled);
  endtask

  task automatic send_random_request(phase_t phase);
    int unsigned               roll;
    int unsigned               pick;
    int unsigned               top;
    logic [ibl_pkg::OP_W-1:0]  op;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      // Noise: anything at all, mostly out of range.
      send_request(ibl_pkg::OP_W'($urandom_range(0, 3)), $urandom_range(0, 63),
                   ibl_pkg::BYTE_W'($urandom));
      return;
    end
    pick = $urandom_range(0, 99);
    case (phase)
      PH_GROW:  op = (pick < 70) ? ibl_pkg::OP_INSERT : (pick < 80) ? ibl_pkg::OP_REMOVE :
                     (pick < 90) ? ibl_pkg::OP_SET : ibl_pkg::OP_GET;
      PH_SHRINK: op = (pick < 15) ? ibl_pkg::OP_INSERT : (pick < 75) ? ibl_pkg::OP_REMOVE :
                      (pick < 87) ? ibl_pkg::OP_SET : ibl_pkg::OP_GET;
      default:  op = (pick < 35) ? ibl_pkg::OP_INSERT : (pick < 65) ? ibl_pkg::OP_REMOVE :
                     (pick < 80) ? ibl_pkg::OP_SET : ibl_pkg::OP_GET;
    endcase
    if (op == ibl_pkg::OP_INSERT) top = (gen_fill > 63) ? 63 : gen_fill;
    else top = (gen_fill == 0) ? 0 : gen_fill - 1;
    send_request(op, $urandom_range(0, top), ibl_pkg::BYTE_W'($urandom));
  endtask

  initial begin
    int     sent;
    int     span;
    phase_t phase;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Empty list: every access out of range, insert past the end refused.
    send_request(ibl_pkg::OP_GET, 0, 8'h00);
    send_request(ibl_pkg::OP_REMOVE, 0, 8'h00);
    send_request(ibl_pkg::OP_SET, 0, 8'hFF);
    send_request(ibl_pkg::OP_INSERT, 1, 8'h11);
    // Build up at the front, the end and the middle.
    send_request(ibl_pkg::OP_INSERT, 0, 8'h00);
    send_request(ibl_pkg::OP_INSERT, 1, 8'hFF);
    send_request(ibl_pkg::OP_INSERT, 0, 8'hA5);
    send_request(ibl_pkg::OP_INSERT, 1, 8'h5A);
    send_request(ibl_pkg::OP_GET, 0, 8'h00);
    send_request(ibl_pkg::OP_GET, 3, 8'h00);
    send_request(ibl_pkg::OP_GET, 4, 8'h00);
    send_request(ibl_pkg::OP_SET, 2, 8'hC3);
    send_request(ibl_pkg::OP_GET, 2, 8'h00);
    send_request(ibl_pkg::OP_SET, 4, 8'h77);
    send_request(ibl_pkg::OP_INSERT, 5, 8'h12);
    // Remove from the middle, the end and the front.
    send_request(ibl_pkg::OP_REMOVE, 1, 8'h00);
    send_request(ibl_pkg::OP_REMOVE, 2, 8'h00);
    send_request(ibl_pkg::OP_REMOVE, 0, 8'h00);
    send_request(ibl_pkg::OP_GET, 63, 8'hFF);
    send_request(ibl_pkg::OP_INSERT, 63, 8'hFF);
    send_request(ibl_pkg::OP_REMOVE, 63, 8'h00);
    send_request(ibl_pkg::OP_REMOVE, 0, 8'h00);
    send_request(ibl_pkg::OP_REMOVE, 0, 8'h00);

    // Phases cycle grow, churn, drain so the list hits full and empty often.
    sent  = 0;
    phase = PH_GROW;
    while (sent < RANDOM_ITEMS) begin
      span    = (phase == PH_MIXED) ? $urandom_range(40, 120) : $urandom_range(90, 160);
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat (span) begin
        send_random_request(phase);
        sent++;
      end
      case (phase)
        PH_GROW:  phase = PH_MIXED;
        PH_MIXED: phase = PH_SHRINK;
        default:  phase = PH_GROW;
      endcase
    end
    start <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("insertable_byte_list_core_tb OK");
    end else begin
      $display("insertable_byte_list_core_tb NOT OK");
    end
    $finish;
  end

endmodule

### insertable_byte_list_core.f
+incdir+sv
sv/ibl_pkg.sv
sv/ibl_cell.sv
sv/insertable_byte_list_core.sv
sv/ibl_checker.sv
sim/insertable_byte_list_core_tb.sv
